[rtl/pgls_pkg.sv]
// Shared types, constants and saturation helpers for the perspective line stepper.
// No dependencies; compiled first.
package pgls_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DVD_W     = 49;
  localparam int DSR_W     = 33;
  localparam int MA_W      = 34;
  localparam int MB_W      = 17;
  localparam int MP_W      = 51;

  localparam logic [2:0] REG_CAMERA_X    = 3'd0;
  localparam logic [2:0] REG_CAMERA_Y    = 3'd1;
  localparam logic [2:0] REG_CAMERA_Z    = 3'd2;
  localparam logic [2:0] REG_CENTER_X    = 3'd3;
  localparam logic [2:0] REG_CENTER_Y    = 3'd4;
  localparam logic [2:0] REG_FOCAL_SCALE = 3'd5;

  localparam logic [5:0] PROJ_DIV_ITERS = 6'd49;
  localparam logic [5:0] STEP_DIV_ITERS = 6'd16;
  localparam logic [4:0] MUL_ITERS      = 5'd17;

  typedef struct packed {
    logic             start;
    logic [DSR_W-1:0] rem_init;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [5:0]       iters;
  } div_req_t;

  typedef struct packed {
    logic                   start;
    logic signed [MA_W-1:0] a;
    logic [MB_W-1:0]        b;
  } mul_req_t;

  function automatic logic [31:0] sat32(input logic signed [51:0] v);
    logic [31:0] res;
    if (v > 52'sd2147483647) res = 32'h7FFF_FFFF;
    else if (v < -52'sd2147483648) res = 32'h8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [35:0] v);
    logic [15:0] res;
    if (v > 36'sd32767) res = 16'h7FFF;
    else if (v < -36'sd32768) res = 16'h8000;
    else res = v[15:0];
    return res;
  endfunction

  function automatic logic [7:0] sat_u8(input logic signed [35:0] v);
    logic [7:0] res;
    if (v < 36'sd0) res = 8'd0;
    else if (v > 36'sd255) res = 8'd255;
    else res = v[7:0];
    return res;
  endfunction

endpackage

[rtl/pgls_if.sv]
// Valid/ready channel interfaces for line items and pixel results.
// No dependencies.
interface pgls_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [23:0]        start_rgb;
  logic [23:0]        end_rgb;
  modport source (output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  start_rgb, end_rgb, input ready);
  modport sink   (input valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                  start_rgb, end_rgb, output ready);
endinterface

interface pgls_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               visible;
  logic               last;
  modport source (output valid, pixel_x, pixel_y, red, green, blue, visible, last,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, visible, last,
                  output ready);
endinterface

[rtl/perspective_gradient_line_stepper.sv]
// Start item: both end points are projected through the serial divider and multiplier; a
// zero depth difference skips that divide.
// Step item: completion divide unless the span is zero or reached, then interpolation multiply,
// then the result register; one item at a time, the result register frees the input side.
// Reset (rst_n, synchronous): line disarmed, result channel empty, registers to defaults.
// Depends on pgls_pkg, pgls_if, pgls_div, pgls_mul.
module perspective_gradient_line_stepper import pgls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pgls_in_if.sink     in_ch,
  pgls_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PDIV   = 4'd1;
  localparam logic [3:0] ST_PDWAIT = 4'd2;
  localparam logic [3:0] ST_PMUL   = 4'd3;
  localparam logic [3:0] ST_PMWAIT = 4'd4;
  localparam logic [3:0] ST_PSTORE = 4'd5;
  localparam logic [3:0] ST_SCHK   = 4'd6;
  localparam logic [3:0] ST_SDWAIT = 4'd7;
  localparam logic [3:0] ST_SMUL   = 4'd8;
  localparam logic [3:0] ST_SMWAIT = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  // configuration
  logic [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [11:0] ctr_x_r, ctr_y_r;
  logic [15:0] focal_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      ctr_x_r <= 12'd320;
      ctr_y_r <= 12'd240;
      focal_r <= 16'd560;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CAMERA_X:    cam_x_r <= pwdata;
        REG_CAMERA_Y:    cam_y_r <= pwdata;
        REG_CAMERA_Z:    cam_z_r <= pwdata;
        REG_CENTER_X:    ctr_x_r <= pwdata[11:0];
        REG_CENTER_Y:    ctr_y_r <= pwdata[11:0];
        REG_FOCAL_SCALE: focal_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CAMERA_X:    prdata = cam_x_r;
      REG_CAMERA_Y:    prdata = cam_y_r;
      REG_CAMERA_Z:    prdata = cam_z_r;
      REG_CENTER_X:    prdata = {20'd0, ctr_x_r};
      REG_CENTER_Y:    prdata = {20'd0, ctr_y_r};
      REG_FOCAL_SCALE: prdata = {16'd0, focal_r};
      default:         prdata = '0;
    endcase
  end

  // control and line state
  logic [3:0]  state_r;
  logic [1:0]  k_r;
  logic        line_active_r;
  logic [15:0] step_r;
  logic [31:0] psx_r, psy_r, pey_r;
  logic [32:0] span_r;
  logic [16:0] t_r;
  logic [31:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic [23:0] crgb_s_r, crgb_e_r;
  logic        out_valid_r;
  logic [15:0] out_px_r, out_py_r;
  logic [7:0]  out_r_r, out_g_r, out_b_r;
  logic        out_vis_r, out_last_r;

  div_req_t        div_req;
  logic            div_busy;
  logic [DVD_W-1:0] div_quot;
  mul_req_t        mul_req [5];
  logic [4:0]      mul_busy;
  logic signed [MP_W-1:0] mul_prod [5];

  pgls_div u_div (
    .clk(clk), .rst_n(rst_n), .req(div_req), .busy(div_busy), .quot(div_quot)
  );

  for (genvar g = 0; g < 5; g++) begin : g_lane
    pgls_mul u_mul (
      .clk(clk), .rst_n(rst_n), .req(mul_req[g]), .busy(mul_busy[g]), .prod(mul_prod[g])
    );
  end

  // projection operands
  logic [31:0]        op_cam, op_p, op_pz;
  logic [11:0]        op_ctr;
  logic signed [32:0] num, dz;
  logic [32:0]        num_abs, dz_abs;
  logic               dz_zero, q_neg;
  logic [31:0]        ratio;
  logic signed [51:0] base, off, proj_sum;
  logic [31:0]        proj_sat;
  logic signed [32:0] span_new;

  always_comb begin
    op_cam   = k_r[0] ? cam_y_r : cam_x_r;
    op_p     = k_r[0] ? (k_r[1] ? ey_r : sy_r) : (k_r[1] ? ex_r : sx_r);
    op_pz    = k_r[1] ? ez_r : sz_r;
    op_ctr   = k_r[0] ? ctr_y_r : ctr_x_r;
    num      = $signed({op_cam[31], op_cam}) - $signed({op_p[31], op_p});
    dz       = $signed({cam_z_r[31], cam_z_r}) - $signed({op_pz[31], op_pz});
    num_abs  = num[32] ? 33'(-num) : num;
    dz_abs   = dz[32] ? 33'(-dz) : dz;
    dz_zero  = (dz == 33'sd0);
    q_neg    = num[32] ^ dz[32];
    if (dz_zero) begin
      if (num > 33'sd0) ratio = 32'h7FFF_FFFF;
      else if (num < 33'sd0) ratio = 32'h8000_0000;
      else ratio = 32'd0;
    end else if (q_neg) begin
      ratio = (div_quot > 49'd2147483648) ? 32'h8000_0000 : 32'(-div_quot);
    end else begin
      ratio = (div_quot > 49'd2147483647) ? 32'h7FFF_FFFF : div_quot[31:0];
    end
    base     = $signed({24'd0, op_ctr, 16'd0});
    off      = {mul_prod[0][MP_W-1], mul_prod[0]};
    proj_sum = k_r[0] ? base - off : base + off;
    proj_sat = sat32(proj_sum);
    span_new = $signed({proj_sat[31], proj_sat}) - $signed({psx_r[31], psx_r});
  end

  // step operands
  logic [32:0]        iiq;
  logic [16:0]        step_p1;
  logic               last_px;
  logic signed [32:0] dy, dzz;
  logic signed [8:0]  dc [3];
  logic signed [35:0] yq, zq, cv [3];
  logic signed [17:0] px_sum;

  always_comb begin
    iiq     = {1'b0, step_r, 16'd0};
    step_p1 = {1'b0, step_r} + 17'd1;
    last_px = ({step_p1, 16'd0} > span_r) || (step_r == 16'hFFFF);
    dy      = $signed({pey_r[31], pey_r}) - $signed({psy_r[31], psy_r});
    dzz     = $signed({ez_r[31], ez_r}) - $signed({sz_r[31], sz_r});
    for (int c = 0; c < 3; c++) begin
      dc[c] = $signed({1'b0, crgb_e_r[16-8*c +: 8]}) - $signed({1'b0, crgb_s_r[16-8*c +: 8]});
      cv[c] = $signed({28'd0, crgb_s_r[16-8*c +: 8]}) +
              36'($signed(mul_prod[2+c][MP_W-1:16]));
    end
    yq      = $signed({{4{psy_r[31]}}, psy_r}) + 36'($signed(mul_prod[0][MP_W-1:16]));
    zq      = $signed({{4{sz_r[31]}}, sz_r}) + 36'($signed(mul_prod[1][MP_W-1:16]));
    px_sum  = $signed({{2{psx_r[31]}}, psx_r[31:16]}) + $signed({2'b00, step_r});
  end

  always_comb begin
    div_req = '0;
    for (int l = 0; l < 5; l++) mul_req[l] = '0;
    case (state_r)
      ST_PDIV: begin
        div_req.start    = !dz_zero;
        div_req.dividend = {num_abs, 16'd0};
        div_req.divisor  = dz_abs;
        div_req.iters    = PROJ_DIV_ITERS;
      end
      ST_SCHK: begin
        div_req.start    = (span_r != 33'd0) && (iiq < span_r);
        div_req.rem_init = iiq;
        div_req.divisor  = span_r;
        div_req.iters    = STEP_DIV_ITERS;
      end
      ST_PMUL: begin
        mul_req[0].start = 1'b1;
        mul_req[0].a     = MA_W'($signed(ratio));
        mul_req[0].b     = {1'b0, focal_r};
      end
      ST_SMUL: begin
        for (int l = 0; l < 5; l++) begin
          mul_req[l].start = 1'b1;
          mul_req[l].b     = t_r;
        end
        mul_req[0].a = MA_W'(dy);
        mul_req[1].a = MA_W'(dzz);
        for (int c = 0; c < 3; c++) mul_req[2+c].a = MA_W'(dc[c]);
      end
      default: ;
    endcase
  end

  logic in_fire, out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      k_r           <= '0;
      line_active_r <= 1'b0;
      step_r        <= '0;
      span_r        <= '0;
      t_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != ST_OUT) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_ch.mode) begin
              line_active_r <= 1'b0;
              k_r           <= 2'd0;
              state_r       <= ST_PDIV;
            end else if (line_active_r) begin
              state_r <= ST_SCHK;
            end
          end
        end
        ST_PDIV:   state_r <= dz_zero ? ST_PMUL : ST_PDWAIT;
        ST_PDWAIT: if (!div_busy) state_r <= ST_PMUL;
        ST_PMUL:   state_r <= ST_PMWAIT;
        ST_PMWAIT: if (!mul_busy[0]) state_r <= ST_PSTORE;
        ST_PSTORE: begin
          k_r <= k_r + 2'd1;
          if (k_r == 2'd2) span_r <= span_new;
          if (k_r == 2'd3) begin
            line_active_r <= !span_r[32];
            step_r        <= '0;
            state_r       <= ST_IDLE;
          end else begin
            state_r <= ST_PDIV;
          end
        end
        ST_SCHK: begin
          if (span_r == 33'd0) begin
            t_r     <= '0;
            state_r <= ST_SMUL;
          end else if (iiq >= span_r) begin
            t_r     <= 17'h10000;
            state_r <= ST_SMUL;
          end else begin
            state_r <= ST_SDWAIT;
          end
        end
        ST_SDWAIT: begin
          if (!div_busy) begin
            t_r     <= {1'b0, div_quot[15:0]};
            state_r <= ST_SMUL;
          end
        end
        ST_SMUL:   state_r <= ST_SMWAIT;
        ST_SMWAIT: if (!mul_busy[0]) state_r <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (last_px) line_active_r <= 1'b0;
            else step_r <= step_r + 16'd1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire && !in_ch.mode) begin
      sx_r     <= in_ch.start_x;
      sy_r     <= in_ch.start_y;
      sz_r     <= in_ch.start_z;
      ex_r     <= in_ch.end_x;
      ey_r     <= in_ch.end_y;
      ez_r     <= in_ch.end_z;
      crgb_s_r <= in_ch.start_rgb;
      crgb_e_r <= in_ch.end_rgb;
    end
    if (state_r == ST_PSTORE) begin
      if (k_r == 2'd0) psx_r <= proj_sat;
      if (k_r == 2'd1) psy_r <= proj_sat;
      if (k_r == 2'd3) pey_r <= proj_sat;
    end
    if (state_r == ST_OUT && out_free) begin
      out_px_r   <= sat16(36'(px_sum));
      out_py_r   <= sat16(36'($signed(yq[35:16])));
      out_r_r    <= sat_u8(cv[0]);
      out_g_r    <= sat_u8(cv[1]);
      out_b_r    <= sat_u8(cv[2]);
      out_vis_r  <= $signed({{4{cam_z_r[31]}}, cam_z_r}) < zq;
      out_last_r <= last_px;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.pixel_x = out_px_r;
  assign out_ch.pixel_y = out_py_r;
  assign out_ch.red     = out_r_r;
  assign out_ch.green   = out_g_r;
  assign out_ch.blue    = out_b_r;
  assign out_ch.visible = out_vis_r;
  assign out_ch.last    = out_last_r;

`ifndef SYNTHESIS
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_busy && mul_busy[0])) else $error("divider and multiplier overlap");
  a_out_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> line_active_r) else $error("pixel without active line");
  a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
    t_r[16] |-> (t_r[15:0] == 16'd0)) else $error("completion above one");
  a_span_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCHK) |-> !span_r[32]) else $error("stepping a reversed line");
  a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.mode) |=> (!out_valid_r || $past(out_valid_r)))
    else $error("start transfer produced a result");
`endif

endmodule

[rtl/pgls_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pgls_pkg.
module pgls_div import pgls_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             busy,
  output logic [DVD_W-1:0] quot
);

  logic             busy_r;
  logic [5:0]       cnt_r;
  logic [DSR_W-1:0] rem_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic [DVD_W-1:0] quot_r;
  logic [DSR_W:0]   rem2;
  logic [DSR_W:0]   rem_sub;
  logic             ge;
  logic [DSR_W-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_r, dvd_r[DVD_W-1]};
    ge      = rem2 >= {1'b0, dsr_r};
    rem_sub = rem2 - {1'b0, dsr_r};
    rem_nxt = ge ? rem_sub[DSR_W-1:0] : rem2[DSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.rem_init;
      dvd_r  <= req.dividend;
      dsr_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
      quot_r <= {quot_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = quot_r;

endmodule

[rtl/pgls_mul.sv]
// Serial shift-add multiplier, signed multiplicand by unsigned multiplier, one bit per cycle.
// Depends on pgls_pkg.
module pgls_mul import pgls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mul_req_t               req,
  output logic                   busy,
  output logic signed [MP_W-1:0] prod
);

  logic            busy_r;
  logic [4:0]      cnt_r;
  logic [MP_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [MP_W-1:0] acc_r;
  logic [MP_W-1:0] acc_nxt;

  assign acc_nxt = acc_r + (b_r[0] ? a_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= MUL_ITERS;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= {{(MP_W-MA_W){req.a[MA_W-1]}}, req.a};
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= {a_r[MP_W-2:0], 1'b0};
      b_r   <= {1'b0, b_r[MB_W-1:1]};
    end
  end

  assign busy = busy_r;
  assign prod = $signed(acc_r);

endmodule

[test/perspective_gradient_line_stepper_tb.sv]
// Testbench for perspective_gradient_line_stepper: directed table, then random line sequences,
// pixels checked against a fixed-point projection/interpolation predictor or a table entry.
// Depends on pgls_pkg, pgls_if and the RTL of the block.
module perspective_gradient_line_stepper_tb import pgls_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;
  localparam int   IDLE_LIMIT = 20000;
  localparam int   DRAIN_CYC  = 300;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIX} chk_e;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic               vis;
    logic               last;
  } pix_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] sx, sy, sz, ex, ey, ez;
    logic [23:0]        c0, c1;
    chk_e               chk;
    pix_t               pix;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pgls_in_if  in_if();
  pgls_out_if out_if();

  perspective_gradient_line_stepper u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // register copy
  longint cam_x = 0, cam_y = 0, cam_z = 0;
  longint ctr_x = 320, ctr_y = 240, focal = 560;
  // line state copy
  bit     ln_active = 0;
  longint ps_x = 0, ps_y = 0, pe_y = 0, span = 0, z0 = 0, z1 = 0;
  longint step_cnt = 0;
  logic [23:0] col0 = '0, col1 = '0;

  pix_t pixel_q[$];
  row_t rows[$];
  row_t cur_row;
  int err_cnt = 0;
  int idle_cnt = 0;
  int sender_idle = 0, recv_stall = 0;
  bit hold = 0;

  function automatic longint sat(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint project(longint cam, longint p, longint cz, longint pz,
                                     longint center, bit inv);
    longint num, dz, ratio, off, base;
    num = cam - p;
    dz = cz - pz;
    if (dz == 0) ratio = num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    else ratio = sat((num * 65536) / dz, 32);
    off = ratio * focal;
    base = center * 65536;
    return sat(inv ? base - off : base + off, 32);
  endfunction

  function automatic longint frac_mul(longint d, longint t);
    return (d * t) >>> 16;
  endfunction

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, longint t);
    longint v;
    v = longint'(a) + frac_mul(longint'(b) - longint'(a), t);
    return v < 0 ? 8'd0 : (v > 255 ? 8'd255 : v[7:0]);
  endfunction

  function automatic bit predict_item(row_t it, output pix_t p);
    longint px1, px2, t, yq, z;
    bit lst;
    p = '0;
    if (it.mode == MODE_START) begin
      px1 = project(cam_x, it.sx, cam_z, it.sz, ctr_x, 1'b0);
      ps_y = project(cam_y, it.sy, cam_z, it.sz, ctr_y, 1'b1);
      px2 = project(cam_x, it.ex, cam_z, it.ez, ctr_x, 1'b0);
      pe_y = project(cam_y, it.ey, cam_z, it.ez, ctr_y, 1'b1);
      ps_x = px1;
      span = px2 - px1;
      z0 = it.sz;
      z1 = it.ez;
      col0 = it.c0;
      col1 = it.c1;
      step_cnt = 0;
      ln_active = span >= 0;
      return 0;
    end
    if (!ln_active) return 0;
    if (span == 0) t = 0;
    else if ((step_cnt <<< 16) >= span) t = 65536;
    else t = (step_cnt <<< 32) / span;
    yq = ps_y + frac_mul(pe_y - ps_y, t);
    z = z0 + frac_mul(z1 - z0, t);
    lst = ((step_cnt + 1) <<< 16) > span || step_cnt >= 65535;
    p.x = 16'(sat((ps_x + (step_cnt <<< 16)) >>> 16, 16));
    p.y = 16'(sat(yq >>> 16, 16));
    p.r = blend(col0[23:16], col1[23:16], t);
    p.g = blend(col0[15:8], col1[15:8], t);
    p.b = blend(col0[7:0], col1[7:0], t);
    p.vis = cam_z < z;
    p.last = lst;
    if (lst) ln_active = 0;
    else step_cnt = step_cnt + 1;
    return 1;
  endfunction

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    row_t it;
    pix_t p, e;
    bit got;
    if (rst_n && in_if.valid && in_if.ready) begin
      it = cur_row;
      got = predict_item(it, p);
      if (it.chk == CHK_PIX) pixel_q.push_back(it.pix);
      else if (it.chk == CHK_MODEL && got) pixel_q.push_back(p);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      p = {out_if.pixel_x, out_if.pixel_y, out_if.red, out_if.green, out_if.blue,
           out_if.visible, out_if.last};
      if (pixel_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected pixel x=%0d y=%0d rgb=%h%h%h vis=%b last=%b", $time,
                 p.x, p.y, p.r, p.g, p.b, p.vis, p.last);
      end else begin
        e = pixel_q.pop_front();
        if (e != p) begin
          err_cnt++;
          $display("%0t: mismatch exp x=%0d y=%0d rgb=%h%h%h vis=%b last=%b", $time,
                   e.x, e.y, e.r, e.g, e.b, e.vis, e.last);
          $display("%0t:          got x=%0d y=%0d rgb=%h%h%h vis=%b last=%b", $time,
                   p.x, p.y, p.r, p.g, p.b, p.vis, p.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("** perspective_gradient_line_stepper: FAILED **");
      $finish;
    end
  end

  initial out_if.ready = 1'b0;
  always @(negedge clk) out_if.ready <= !hold && ($urandom_range(99) >= recv_stall);

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAMERA_X:    cam_x = longint'($signed(val));
      REG_CAMERA_Y:    cam_y = longint'($signed(val));
      REG_CAMERA_Z:    cam_z = longint'($signed(val));
      REG_CENTER_X:    ctr_x = longint'(val[11:0]);
      REG_CENTER_Y:    ctr_y = longint'(val[11:0]);
      REG_FOCAL_SCALE: focal = longint'(val[15:0]);
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic send(row_t r);
    while ($urandom_range(99) < sender_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    cur_row = r;
    {in_if.mode, in_if.start_x, in_if.start_y, in_if.start_z, in_if.end_x, in_if.end_y,
     in_if.end_z, in_if.start_rgb, in_if.end_rgb} =
      {r.mode, r.sx, r.sy, r.sz, r.ex, r.ey, r.ez, r.c0, r.c1};
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_if.valid = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  function automatic row_t mk(logic mode, logic [31:0] sx, sy, sz, ex, ey, ez,
                              logic [23:0] c0, c1, chk_e chk, pix_t pix);
    row_t r;
    r = {mode, sx, sy, sz, ex, ey, ez, c0, c1, chk, pix};
    return r;
  endfunction

  function automatic logic [31:0] near(longint base, int span_units);
    longint d;
    d = longint'($urandom_range(span_units * 131072)) - span_units * 65536;
    return 32'(base + d);
  endfunction

  task automatic random_phase(int count);
    row_t r;
    int n, k;
    n = 0;
    r = '0;
    r.mode = MODE_STEP;
    r.chk = CHK_MODEL;
    repeat ($urandom_range(1, 6)) begin send(r); n++; end
    while (n < count) begin
      if ($urandom_range(99) < 10) begin
        r = '0;
        r.mode = 1'($urandom_range(1));
        r.sx = $urandom;
        r.sy = $urandom;
        r.sz = $urandom;
        r.ex = $urandom;
        r.ey = $urandom;
        r.ez = $urandom;
        r.c0 = 24'($urandom);
        r.c1 = 24'($urandom);
        r.chk = CHK_MODEL;
        send(r);
        n++;
        continue;
      end
      r.mode = MODE_START;
      r.sx = near(cam_x, 8);
      r.sy = near(cam_y, 8);
      r.sz = near(cam_z - 8 * 65536, 8);
      r.ex = 32'(longint'(r.sx) + longint'($urandom_range(65536 * 3)) - 32768);
      r.ey = near(cam_y, 8);
      r.ez = near(cam_z - 8 * 65536, 8);
      r.c0 = 24'($urandom);
      r.c1 = 24'($urandom);
      r.chk = CHK_MODEL;
      send(r);
      n++;
      r.mode = MODE_STEP;
      k = $urandom_range(1, 24);
      repeat (k) begin send(r); n++; end
      if ($urandom_range(99) < 3) begin
        in_if.valid = 1'b0;
        wait (pixel_q.size() == 0);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    pix_t p;
    in_if.valid = 1'b0;
    cur_row = '0;
    {in_if.mode, in_if.start_x, in_if.start_y, in_if.start_z, in_if.end_x, in_if.end_y,
     in_if.end_z, in_if.start_rgb, in_if.end_rgb} = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // step with no line, single-point line, zero depth, end left of start, stepped line, extremes
    rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_NONE, '0));
    rows.push_back(mk(MODE_START, 0, 0, -65536, 0, 0, -65536, 24'h123456, 24'hABCDEF,
                      CHK_MODEL, '0));
    p = {16'sd320, 16'sd240, 8'h12, 8'h34, 8'h56, 1'b0, 1'b1};
    rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_PIX, p));
    rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_NONE, '0));
    rows.push_back(mk(MODE_START, -65536, 0, 0, -65536, 0, 0, 24'hFFFFFF, 24'h000000,
                      CHK_MODEL, '0));
    p = {16'sd32767, 16'sd240, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1};
    rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_PIX, p));
    rows.push_back(mk(MODE_START, -65536, 0, -65536, 65536, 0, -65536, 0, 0,
                      CHK_MODEL, '0));
    rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_NONE, '0));
    rows.push_back(mk(MODE_START, -131072, 65536, -262144, 131072, -65536, -131072,
                      24'h000000, 24'hFFFFFF, CHK_MODEL, '0));
    repeat (6) rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
    rows.push_back(mk(MODE_START, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 24'h000000, CHK_MODEL, '0));
    repeat (2) rows.push_back(mk(MODE_STEP, '1, '1, '1, '1, '1, '1, '1, '1, CHK_MODEL, '0));
    rows.push_back(mk(MODE_START, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 24'h000000, 24'hFFFFFF, CHK_MODEL, '0));
    repeat (2) rows.push_back(mk(MODE_STEP, 0, 0, 0, 0, 0, 0, 0, 0, CHK_MODEL, '0));
    foreach (rows[i]) send(rows[i]);

    // phase: no idling, with a long receiver hold-off
    fork
      begin
        hold = 1;
        repeat (1500) @(negedge clk);
        hold = 0;
      end
    join_none
    random_phase(225);
    quiesce();

    reg_write(REG_CAMERA_X, 32'h0003_0000);
    reg_write(REG_CAMERA_Y, 32'hFFFE_8000);
    reg_write(REG_CAMERA_Z, 32'h0001_0000);
    reg_write(REG_CENTER_X, 32'd0);
    reg_write(REG_CENTER_Y, 32'd0);
    reg_write(REG_FOCAL_SCALE, 32'd0);
    reg_write(3'd6, 32'hFFFF_FFFF);
    sender_idle = 78; recv_stall = 0;
    random_phase(225);
    quiesce();

    reg_write(REG_CAMERA_X, 32'h8000_0000);
    reg_write(REG_CAMERA_Y, 32'h7FFF_FFFF);
    reg_write(REG_CAMERA_Z, 32'h7FFF_FFFF);
    reg_write(REG_CENTER_X, 32'hFFFF_FFFF);
    reg_write(REG_CENTER_Y, 32'hFFFF_FFFF);
    reg_write(REG_FOCAL_SCALE, 32'hFFFF_FFFF);
    sender_idle = 0; recv_stall = 78;
    random_phase(225);
    quiesce();

    reg_write(REG_CAMERA_X, $urandom_range(65536 * 4) - 131072);
    reg_write(REG_CAMERA_Y, $urandom_range(65536 * 4) - 131072);
    reg_write(REG_CAMERA_Z, $urandom_range(65536 * 4) - 131072);
    reg_write(REG_CENTER_X, $urandom_range(4095));
    reg_write(REG_CENTER_Y, $urandom_range(4095));
    reg_write(REG_FOCAL_SCALE, $urandom_range(16, 2000));
    sender_idle = 24; recv_stall = 24;
    random_phase(225);

    in_if.valid = 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_cnt == 0 && pixel_q.size() == 0)
      $display("** perspective_gradient_line_stepper: PASSED **");
    else
      $display("** perspective_gradient_line_stepper: FAILED **");
    $finish;
  end

endmodule

[files.f]
rtl/pgls_pkg.sv
rtl/pgls_if.sv
rtl/pgls_div.sv
rtl/pgls_mul.sv
rtl/perspective_gradient_line_stepper.sv
test/perspective_gradient_line_stepper_tb.sv
